[rtl/bbss_pkg.sv]
// Shared types and constants for the buzzer beep and song sequencer.
// Request and result payloads, opcode and compare-action codes, tone constants.
// No dependencies.
`default_nettype none

package bbss_pkg;

  // Field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned TONE_W  = 16;
  localparam int unsigned VOL_W   = 7;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned NOTE_W  = 2 * NIB_W;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned SLOT_SPAN = 2 ** SLOT_W;
  localparam int unsigned PROD_W  = TONE_W + VOL_W;

  // Defaults and tone constants
  localparam int unsigned SONG_DEPTH_DEF        = 256;
  localparam int unsigned BASE_PERIOD           = 61156;
  localparam int unsigned SEMITONE_RATIO_X10000 = 10595;
  localparam int unsigned RATIO_SCALE           = 10000;
  localparam logic [NIB_W-1:0] END_LETTER       = 4'd13;

  // Volume register
  localparam logic [VOL_W-1:0] VOL_RESET = 7'd50;
  localparam logic [VOL_W-1:0] VOL_MAX   = 7'd100;

  // Divide by 100 as multiply by ceil(2^30/100), exact for products below 2^23
  localparam int unsigned RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
  localparam int unsigned RECIP_SHIFT = 30;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_BEEP_START = 3'd1,
    OP_NOTE_WR    = 3'd2,
    OP_SONG_START = 3'd3,
    OP_SONG_STOP  = 3'd4
  } op_t;

  // What the duty stage does with the compare value
  typedef enum logic [1:0] {
    CMP_KEEP  = 2'd0,
    CMP_ZERO  = 2'd1,
    CMP_SOUND = 2'd2
  } cmp_op_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CNT_W-1:0]  beep_count;
    logic [TONE_W-1:0] beep_period;
    logic [NIB_W-1:0]  note_letter;
    logic [NIB_W-1:0]  note_octave;
    logic [SLOT_W-1:0] song_slot;
    logic [TONE_W-1:0] note_length_ms;
    logic [TONE_W-1:0] break_ms;
  } in_req_t;

  typedef struct packed {
    logic [TONE_W-1:0] pwm_period;
    logic [TONE_W-1:0] pwm_compare;
    logic              pattern_active;
    logic              song_active;
  } out_rsp_t;

  // Execute stage to duty stage
  typedef struct packed {
    logic [PROD_W-1:0] prod;
    cmp_op_t           cmp_op;
    logic [TONE_W-1:0] pwm_period;
    logic              pattern_active;
    logic              song_active;
  } duty_req_t;

endpackage

`default_nettype wire

[rtl/bbss_chan_if.sv]
// Valid/ready channel carrying one payload of type T.
// Used for the request, result and volume channels. No dependencies.
`default_nettype none

interface bbss_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/bbss_note_mem.sv]
// Song note store: one write port, one read port, registered read data.
// Contents are undefined until written. Uses bbss_pkg.
`default_nettype none

module bbss_note_mem #(
  parameter int unsigned SONG_DEPTH = bbss_pkg::SONG_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(SONG_DEPTH)-1:0]   wr_addr,
  input  logic [bbss_pkg::NOTE_W-1:0]     wr_data,
  input  logic                            rd_en,
  input  logic [$clog2(SONG_DEPTH)-1:0]   rd_addr,
  output logic [bbss_pkg::NOTE_W-1:0]     rd_data
);
  import bbss_pkg::*;

  logic [NOTE_W-1:0] mem [SONG_DEPTH];
  logic [NOTE_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/bbss_exec.sv]
// Execute stage: holds the sequencer state, applies one request per cycle while
// the duty stage takes results, using the note read from the song store, and
// forms period*volume. Uses bbss_pkg.
`default_nettype none

module bbss_exec #(
  parameter int unsigned SONG_DEPTH = bbss_pkg::SONG_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_fire,
  input  bbss_pkg::in_req_t                 in_req,
  input  logic [$clog2(SONG_DEPTH)-1:0]     in_slot,
  output logic                              in_ready,
  input  logic [bbss_pkg::VOL_W-1:0]        volume,
  input  logic [bbss_pkg::NOTE_W-1:0]       rd_note,
  output logic [$clog2(SONG_DEPTH)-1:0]     pos_ahead,
  output logic                              s3_valid,
  output bbss_pkg::duty_req_t               s3_data,
  input  logic                              s3_ready
);
  import bbss_pkg::*;

  localparam int unsigned PW = $clog2(SONG_DEPTH);
  localparam logic [PW-1:0] POS_LAST = PW'(SONG_DEPTH - 1);

  // Octave-0 periods, each semitone the previous one divided by the ratio
  localparam int unsigned T1  = BASE_PERIOD;
  localparam int unsigned T2  = T1  * RATIO_SCALE / SEMITONE_RATIO_X10000;
  localparam int unsigned T3  = T2  * RATIO_SCALE / SEMITONE_RATIO_X10000;
  localparam int unsigned T4  = T3  * RATIO_SCALE / SEMITONE_RATIO_X10000;
  localparam int unsigned T5  = T4  * RATIO_SCALE / SEMITONE_RATIO_X10000;
  localparam int unsigned T6  = T5  * RATIO_SCALE / SEMITONE_RATIO_X10000;
  localparam int unsigned T7  = T6  * RATIO_SCALE / SEMITONE_RATIO_X10000;
  localparam int unsigned T8  = T7  * RATIO_SCALE / SEMITONE_RATIO_X10000;
  localparam int unsigned T9  = T8  * RATIO_SCALE / SEMITONE_RATIO_X10000;
  localparam int unsigned T10 = T9  * RATIO_SCALE / SEMITONE_RATIO_X10000;
  localparam int unsigned T11 = T10 * RATIO_SCALE / SEMITONE_RATIO_X10000;
  localparam int unsigned T12 = T11 * RATIO_SCALE / SEMITONE_RATIO_X10000;

  // Rest, end and unused letters give period zero
  function automatic logic [TONE_W-1:0] tone_base(input logic [NIB_W-1:0] letter);
    logic [TONE_W-1:0] t;
    case (letter)
      4'd1:    t = TONE_W'(T1);
      4'd2:    t = TONE_W'(T2);
      4'd3:    t = TONE_W'(T3);
      4'd4:    t = TONE_W'(T4);
      4'd5:    t = TONE_W'(T5);
      4'd6:    t = TONE_W'(T6);
      4'd7:    t = TONE_W'(T7);
      4'd8:    t = TONE_W'(T8);
      4'd9:    t = TONE_W'(T9);
      4'd10:   t = TONE_W'(T10);
      4'd11:   t = TONE_W'(T11);
      4'd12:   t = TONE_W'(T12);
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [TONE_W-1:0] period_of(input logic [NOTE_W-1:0] note);
    return tone_base(note[NIB_W-1:0]) >> note[NOTE_W-1:NIB_W];
  endfunction

  function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
    return (p == POS_LAST) ? '0 : PW'(p + 1'b1);
  endfunction

  // Request register
  logic              s2_v_r;
  in_req_t           s2_req_r;
  logic [PW-1:0]     s2_slot_r;
  logic              s2_fire;
  logic              s3_en;

  // Sequencer state
  logic              beep_on_r, beep_on_nxt;
  logic [CNT_W-1:0]  beeps_left_r, beeps_left_nxt;
  logic [TONE_W-1:0] beep_ival_r, beep_ival_nxt;
  logic [TONE_W-1:0] beep_ticks_r, beep_ticks_nxt;
  logic [TONE_W-1:0] tone_r, tone_nxt;
  logic [TONE_W-1:0] reload_r, reload_nxt;
  logic              playing_r, playing_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [TONE_W-1:0] len_each_r, len_each_nxt;
  logic [TONE_W-1:0] len_rem_r, len_rem_nxt;
  logic [TONE_W-1:0] gap_len_r, gap_len_nxt;
  logic              in_gap_r, in_gap_nxt;
  logic [NOTE_W-1:0] cur_note_r, cur_note_nxt;

  logic              s3_v_r;
  duty_req_t         s3_r, s3_nxt;

  logic [TONE_W-1:0] ticks_dec;
  logic [TONE_W-1:0] note_per;
  logic [TONE_W-1:0] req_per;
  logic              load_note;
  logic              advance;
  cmp_op_t           cmp_op;

  assign s3_en    = !s3_v_r || s3_ready;
  assign s2_fire  = s2_v_r && s3_en;
  assign in_ready = !s2_v_r || s3_en;

  // Position seen by the next request; the store is read one slot ahead of it
  assign pos_ahead = pos_inc(s2_fire ? pos_nxt : pos_r);

  // Request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (in_fire) begin
      s2_v_r <= 1'b1;
    end else if (s2_fire) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s2_req_r  <= in_req;
      s2_slot_r <= in_slot;
    end
  end

  // Next state for the request in the execute stage
  always_comb begin
    beep_on_nxt    = beep_on_r;
    beeps_left_nxt = beeps_left_r;
    beep_ival_nxt  = beep_ival_r;
    beep_ticks_nxt = beep_ticks_r;
    tone_nxt       = tone_r;
    reload_nxt     = reload_r;
    playing_nxt    = playing_r;
    pos_nxt        = pos_r;
    len_each_nxt   = len_each_r;
    len_rem_nxt    = len_rem_r;
    gap_len_nxt    = gap_len_r;
    in_gap_nxt     = in_gap_r;
    cur_note_nxt   = cur_note_r;
    cmp_op         = CMP_KEEP;
    load_note      = 1'b0;
    advance        = 1'b0;
    ticks_dec      = TONE_W'(beep_ticks_r - 1'b1);
    note_per       = period_of(rd_note);
    req_per        = period_of({s2_req_r.note_octave, s2_req_r.note_letter});

    case (s2_req_r.opcode)
      OP_TICK: begin
        if (beep_on_r || beeps_left_r != '0) begin
          // Beep pattern has priority over the song
          beep_ticks_nxt = ticks_dec;
          if (ticks_dec == '0) begin
            beep_on_nxt    = !beep_on_r;
            cmp_op         = beep_on_r ? CMP_ZERO : CMP_SOUND;
            beep_ticks_nxt = beep_ival_r;
            if (beep_on_r) begin
              beeps_left_nxt = CNT_W'(beeps_left_r - 1'b1);
            end
          end
        end else if (playing_r) begin
          if (cur_note_r[NIB_W-1:0] == END_LETTER) begin
            playing_nxt = 1'b0;
            cmp_op      = CMP_ZERO;
          end else if (len_rem_r != '0) begin
            len_rem_nxt = TONE_W'(len_rem_r - 1'b1);
          end else begin
            len_rem_nxt = len_each_r;
            advance     = (gap_len_r == '0);
            if (gap_len_r != '0) begin
              in_gap_nxt = !in_gap_r;
              if (!in_gap_r) begin
                len_rem_nxt = gap_len_r;
                cmp_op      = CMP_ZERO;
              end else begin
                advance = 1'b1;
              end
            end
            if (advance) begin
              pos_nxt      = pos_inc(pos_r);
              cur_note_nxt = rd_note;
              load_note    = 1'b1;
            end
          end
        end
      end
      OP_BEEP_START: begin
        tone_nxt = req_per;
        if (req_per != '0) begin
          reload_nxt = req_per;
        end else begin
          cmp_op = CMP_ZERO;
        end
        if (s2_req_r.beep_count != '0 && s2_req_r.beep_period != '0) begin
          beeps_left_nxt = s2_req_r.beep_count;
          beep_ival_nxt  = s2_req_r.beep_period;
          beep_ticks_nxt = s2_req_r.beep_period;
          beep_on_nxt    = 1'b1;
          playing_nxt    = 1'b0;
          cmp_op         = CMP_SOUND;
        end
      end
      OP_NOTE_WR: begin
        // Keep the shadow of the current slot coherent with the store
        if (s2_slot_r == pos_r) begin
          cur_note_nxt = {s2_req_r.note_octave, s2_req_r.note_letter};
        end
      end
      OP_SONG_START: begin
        beep_on_nxt    = 1'b0;
        beeps_left_nxt = '0;
        playing_nxt    = 1'b1;
        pos_nxt        = '0;
        len_each_nxt   = s2_req_r.note_length_ms;
        len_rem_nxt    = s2_req_r.note_length_ms;
        gap_len_nxt    = s2_req_r.break_ms;
        in_gap_nxt     = 1'b0;
        cur_note_nxt   = rd_note;
        load_note      = 1'b1;
      end
      OP_SONG_STOP: begin
        playing_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    // Loading a note sets the tone and turns the sound on
    if (load_note) begin
      tone_nxt = note_per;
      if (note_per != '0) begin
        reload_nxt = note_per;
      end
      cmp_op = CMP_SOUND;
    end

    s3_nxt.prod           = PROD_W'(tone_nxt) * PROD_W'(volume);
    s3_nxt.cmp_op         = cmp_op;
    s3_nxt.pwm_period     = reload_nxt;
    s3_nxt.pattern_active = beep_on_nxt || (beeps_left_nxt != '0);
    s3_nxt.song_active    = playing_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beep_on_r    <= 1'b0;
      beeps_left_r <= '0;
      beep_ival_r  <= '0;
      beep_ticks_r <= '0;
      tone_r       <= TONE_W'(1);
      reload_r     <= TONE_W'(1);
      playing_r    <= 1'b0;
      pos_r        <= '0;
      len_each_r   <= '0;
      len_rem_r    <= '0;
      gap_len_r    <= '0;
      in_gap_r     <= 1'b0;
    end else if (s2_fire) begin
      beep_on_r    <= beep_on_nxt;
      beeps_left_r <= beeps_left_nxt;
      beep_ival_r  <= beep_ival_nxt;
      beep_ticks_r <= beep_ticks_nxt;
      tone_r       <= tone_nxt;
      reload_r     <= reload_nxt;
      playing_r    <= playing_nxt;
      pos_r        <= pos_nxt;
      len_each_r   <= len_each_nxt;
      len_rem_r    <= len_rem_nxt;
      gap_len_r    <= gap_len_nxt;
      in_gap_r     <= in_gap_nxt;
    end
  end

  // Shadow of the note at the current position
  always_ff @(posedge clk) begin
    if (s2_fire) begin
      cur_note_r <= cur_note_nxt;
    end
  end

  // Register toward the duty stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s2_fire) begin
      s3_v_r <= 1'b1;
    end else if (s3_ready) begin
      s3_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      s3_r <= s3_nxt;
    end
  end

  assign s3_valid = s3_v_r;
  assign s3_data  = s3_r;

  a_start_song: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && s2_req_r.opcode == OP_SONG_START) |=>
      (s3_v_r && s3_r.song_active && !s3_r.pattern_active && s3_r.cmp_op == CMP_SOUND))
    else $error("song start did not report an active song");

  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> !(s3_r.pattern_active && s3_r.song_active))
    else $error("beep pattern and song active together");

  a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s3_en) |=> (s2_v_r && $stable(s2_req_r) && $stable(pos_r)))
    else $error("stalled request or position changed");

endmodule

`default_nettype wire

[rtl/bbss_duty.sv]
// Duty stage: divides period*volume by 100 through a reciprocal multiply,
// keeps the compare value and holds the result register. Uses bbss_pkg.
`default_nettype none

module bbss_duty (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s3_valid,
  input  bbss_pkg::duty_req_t       s3_data,
  output logic                      s3_ready,
  output logic                      out_valid,
  output bbss_pkg::out_rsp_t        out_data,
  input  logic                      out_ready
);
  import bbss_pkg::*;

  localparam int unsigned QP_W = PROD_W + RECIP_W;

  logic              s3_fire;
  logic [QP_W-1:0]   quot_prod;
  logic [TONE_W-1:0] quot;
  logic [TONE_W-1:0] compare_r, compare_nxt;
  logic              out_v_r;
  logic [TONE_W-1:0] period_r;
  logic              pattern_r;
  logic              song_r;

  assign s3_ready = !out_v_r || out_ready;
  assign s3_fire  = s3_valid && s3_ready;

  // floor(prod / 100)
  assign quot_prod = QP_W'(s3_data.prod) * QP_W'(RECIP_100);
  assign quot      = quot_prod[RECIP_SHIFT +: TONE_W];

  always_comb begin
    case (s3_data.cmp_op)
      CMP_KEEP:  compare_nxt = compare_r;
      CMP_ZERO:  compare_nxt = '0;
      CMP_SOUND: compare_nxt = quot;
      default:   compare_nxt = compare_r;
    endcase
  end

  // Compare value and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compare_r <= '0;
      out_v_r   <= 1'b0;
    end else if (s3_fire) begin
      compare_r <= compare_nxt;
      out_v_r   <= 1'b1;
    end else if (out_ready) begin
      out_v_r   <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (s3_fire) begin
      period_r  <= s3_data.pwm_period;
      pattern_r <= s3_data.pattern_active;
      song_r    <= s3_data.song_active;
    end
  end

  assign out_valid               = out_v_r;
  assign out_data.pwm_period     = period_r;
  assign out_data.pwm_compare    = compare_r;
  assign out_data.pattern_active = pattern_r;
  assign out_data.song_active    = song_r;

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_fire && s3_data.cmp_op == CMP_ZERO) |=> (out_v_r && compare_r == '0))
    else $error("silence request left a nonzero compare");

  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_fire && s3_data.cmp_op == CMP_KEEP) |=> $stable(compare_r))
    else $error("compare changed without a sound request");

  a_silent_tone: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_fire && s3_data.cmp_op == CMP_SOUND && s3_data.prod == '0) |=> (compare_r == '0))
    else $error("zero tone produced a nonzero compare");

endmodule

`default_nettype wire

[rtl/buzzer_beep_and_song_sequencer_unit.sv]
// Buzzer beep and song sequencer, top level.
// Channels: in_ch carries one request per handshake (1 ms tick, beep pattern
// start, song note write, song start, song stop); out_ch returns one result per
// request: PWM reload, PWM compare and the pattern/song activity flags.
// cfg_ch writes the volume register (duty percent, clamped to 100); it is
// always ready; the user must write it only while no request is in flight,
// which the block does not enforce. A request passes the store read and
// request capture at acceptance, then execute, then the duty divide.
// Throughput: one request per cycle while out_ch does not stall, bounded by
// the state update in the execute stage, which also forwards the song position
// so the note store read for the next request stays in order.
// Reset: synchronous, active low; period 1, compare 0, volume 50, nothing
// playing. The note store is not cleared: song slots must be written before a
// song reaches them.
// Stall: when out_ch is not ready the result register holds, the pipeline
// fills behind it and in_ch.ready drops once no stage is free.
// Uses bbss_pkg, bbss_chan_if, bbss_note_mem, bbss_exec, bbss_duty.
`default_nettype none

module buzzer_beep_and_song_sequencer_unit #(
  parameter int unsigned SONG_DEPTH = bbss_pkg::SONG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bbss_chan_if.sink   in_ch,
  bbss_chan_if.source out_ch,
  bbss_chan_if.sink   cfg_ch
);
  import bbss_pkg::*;

  localparam int unsigned PW = $clog2(SONG_DEPTH);

  in_req_t           in_req;
  logic              in_rdy;
  logic              in_fire;
  logic [PW-1:0]     slot_mod [SLOT_SPAN];
  logic [PW-1:0]     slot_idx;
  logic [PW-1:0]     pos_ahead;
  logic [PW-1:0]     rd_addr;
  logic [NOTE_W-1:0] rd_note;
  logic              wr_en;
  logic              rd_en;
  logic [VOL_W-1:0]  volume_r;
  logic [VOL_W-1:0]  cfg_val;
  logic              s3_valid;
  logic              s3_ready;
  duty_req_t         s3_data;
  out_rsp_t          out_data;
  logic              out_valid;

  assign in_req      = in_ch.data;
  assign in_ch.ready = in_rdy;
  assign in_fire     = in_ch.valid && in_rdy;

  // Slot number folded into the store depth
  for (genvar g = 0; g < SLOT_SPAN; g++) begin : g_slot
    assign slot_mod[g] = PW'(g % SONG_DEPTH);
  end
  assign slot_idx = slot_mod[in_req.song_slot];

  // Store access: writes for note requests, otherwise read slot 0 for a song
  // start or the slot after the current position
  assign wr_en   = in_fire && (in_req.opcode == OP_NOTE_WR);
  assign rd_en   = in_fire && (in_req.opcode != OP_NOTE_WR);
  assign rd_addr = (in_req.opcode == OP_SONG_START) ? '0 : pos_ahead;

  // Volume register
  assign cfg_ch.ready = 1'b1;
  assign cfg_val      = VOL_W'(cfg_ch.data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= VOL_RESET;
    end else if (cfg_ch.valid) begin
      volume_r <= (cfg_val > VOL_MAX) ? VOL_MAX : cfg_val;
    end
  end

  bbss_note_mem #(
    .SONG_DEPTH (SONG_DEPTH)
  ) u_note_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_idx),
    .wr_data ({in_req.note_octave, in_req.note_letter}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_note)
  );

  bbss_exec #(
    .SONG_DEPTH (SONG_DEPTH)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_req    (in_req),
    .in_slot   (slot_idx),
    .in_ready  (in_rdy),
    .volume    (volume_r),
    .rd_note   (rd_note),
    .pos_ahead (pos_ahead),
    .s3_valid  (s3_valid),
    .s3_data   (s3_data),
    .s3_ready  (s3_ready)
  );

  bbss_duty u_duty (
    .clk       (clk),
    .rst_n     (rst_n),
    .s3_valid  (s3_valid),
    .s3_data   (s3_data),
    .s3_ready  (s3_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_ready (out_ch.ready)
  );

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

endmodule

`default_nettype wire

[tb/bbss_pwm_checker.sv]
// Result checker for the buzzer beep and song sequencer: watches the request,
// result and volume channels, predicts PWM reload/compare and activity flags.
// Depends on bbss_pkg.
module bbss_pwm_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  bbss_pkg::in_req_t           in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  bbss_pkg::out_rsp_t          out_data,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [bbss_pkg::VOL_W-1:0]  cfg_data,
  output int unsigned                 fail_count,
  output int unsigned                 pending,
  output int unsigned                 checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import bbss_pkg::*;

  localparam int unsigned    NOTE_COUNT  = 12;
  localparam int unsigned    PERCENT     = 100;
  localparam logic [NIB_W-1:0] LETTER_REST = 4'd0;

  // Octave-0 periods for C..B; entry 0 unused
  logic [TONE_W-1:0] pitch_tbl [NOTE_COUNT+1];

  // Predicted block state
  logic [VOL_W-1:0]  volume;
  logic              sound_phase;
  logic [CNT_W-1:0]  beeps_rem;
  logic [TONE_W-1:0] beep_len;
  logic [TONE_W-1:0] beep_cnt;
  logic [TONE_W-1:0] tone;
  logic [TONE_W-1:0] reload;
  logic [TONE_W-1:0] cmp_val;
  logic              song_on;
  logic [SLOT_W-1:0] song_pos;
  logic [TONE_W-1:0] note_len;
  logic [TONE_W-1:0] note_cnt;
  logic [TONE_W-1:0] break_len;
  logic              resting;
  logic [NOTE_W-1:0] note_store [SLOT_SPAN];

  // Expected results, oldest first
  out_rsp_t pwm_expected [$];

  initial begin
    pitch_tbl[0] = '0;
    pitch_tbl[1] = TONE_W'(BASE_PERIOD);
    for (int i = 2; i <= NOTE_COUNT; i++) begin
      pitch_tbl[i] = TONE_W'(32'(pitch_tbl[i-1]) * RATIO_SCALE / SEMITONE_RATIO_X10000);
    end
    for (int i = 0; i < SLOT_SPAN; i++) begin
      note_store[i] = '0;
    end
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic logic [TONE_W-1:0] pitch_of(input logic [NIB_W-1:0] letter,
                                                 input logic [NIB_W-1:0] octave);
    if (letter == LETTER_REST || letter >= END_LETTER) return '0;
    return pitch_tbl[letter] >> octave;
  endfunction

  // A zero period silences but keeps the old reload
  function automatic void load_tone(input logic [TONE_W-1:0] p);
    tone = p;
    if (p != '0) reload = p;
    else cmp_val = '0;
  endfunction

  function automatic void sound_on();
    int unsigned prod;
    if (tone == '0) begin
      cmp_val = '0;
    end else begin
      prod    = 32'(tone) * 32'(volume);
      cmp_val = TONE_W'(prod / PERCENT);
    end
  endfunction

  function automatic void load_stored(input logic [NOTE_W-1:0] n);
    load_tone(pitch_of(n[NIB_W-1:0], n[NOTE_W-1:NIB_W]));
  endfunction

  // 1 ms tick: pattern first, song only when no pattern runs
  function automatic void apply_tick();
    if (sound_phase || beeps_rem != '0) begin
      beep_cnt = beep_cnt - 1'b1;
      if (beep_cnt == '0) begin
        sound_phase = !sound_phase;
        if (sound_phase) sound_on();
        else cmp_val = '0;
        beep_cnt = beep_len;
        if (!sound_phase) beeps_rem = beeps_rem - 1'b1;
      end
    end else if (song_on) begin
      if (note_store[song_pos][NIB_W-1:0] == END_LETTER) begin
        // end marker: stop and silence, nothing else this tick
        song_on = 1'b0;
        cmp_val = '0;
      end else if (note_cnt > '0) begin
        note_cnt = note_cnt - 1'b1;
      end else begin
        note_cnt = note_len;
        if (break_len != '0) begin
          resting = !resting;
          if (resting) begin
            note_cnt = break_len;
            cmp_val  = '0;
          end else begin
            sound_on();
          end
        end
        if (break_len == '0 || !resting) begin
          song_pos = song_pos + 1'b1;
          load_stored(note_store[song_pos]);
          sound_on();
        end
      end
    end
  endfunction

  function automatic void apply_request(input in_req_t r);
    case (r.opcode)
      OP_TICK: apply_tick();
      OP_BEEP_START: begin
        load_tone(pitch_of(r.note_letter, r.note_octave));
        if (r.beep_count != '0 && r.beep_period != '0) begin
          beeps_rem   = r.beep_count;
          beep_len    = r.beep_period;
          beep_cnt    = r.beep_period;
          sound_phase = 1'b1;
          sound_on();
          song_on     = 1'b0;
        end
      end
      OP_NOTE_WR: note_store[r.song_slot] = {r.note_octave, r.note_letter};
      OP_SONG_START: begin
        sound_phase = 1'b0;
        beeps_rem   = '0;
        song_on     = 1'b1;
        song_pos    = '0;
        note_len    = r.note_length_ms;
        note_cnt    = r.note_length_ms;
        break_len   = r.break_ms;
        resting     = 1'b0;
        load_stored(note_store[0]);
        sound_on();
      end
      OP_SONG_STOP: song_on = 1'b0;
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    out_rsp_t want;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      volume      = VOL_RESET;
      sound_phase = 1'b0;
      beeps_rem   = '0;
      beep_len    = '0;
      beep_cnt    = '0;
      tone        = TONE_W'(1);
      reload      = TONE_W'(1);
      cmp_val     = '0;
      song_on     = 1'b0;
      song_pos    = '0;
      note_len    = '0;
      note_cnt    = '0;
      break_len   = '0;
      resting     = 1'b0;
      pwm_expected.delete();
    end else begin
      // volume writes clamp to 100 percent
      if (cfg_valid && cfg_ready) begin
        volume = (cfg_data > VOL_MAX) ? VOL_MAX : cfg_data;
      end
      if (in_valid && in_ready) begin
        apply_request(in_data);
        want.pwm_period     = reload;
        want.pwm_compare    = cmp_val;
        want.pattern_active = sound_phase || beeps_rem != '0;
        want.song_active    = song_on;
        pwm_expected.push_back(want);
      end
      // compare each accepted result with the oldest prediction
      if (out_valid && out_ready) begin
        if (pwm_expected.size() == 0) begin
          $display("%0t ns: result with nothing outstanding, actual period %0d compare %0d",
                   $time, out_data.pwm_period, out_data.pwm_compare);
          errs++;
        end else begin
          want = pwm_expected.pop_front();
          if (out_data.pwm_period !== want.pwm_period) begin
            $display("%0t ns: pwm_period expected %0d actual %0d",
                     $time, want.pwm_period, out_data.pwm_period);
            errs++;
          end
          if (out_data.pwm_compare !== want.pwm_compare) begin
            $display("%0t ns: pwm_compare expected %0d actual %0d",
                     $time, want.pwm_compare, out_data.pwm_compare);
            errs++;
          end
          if (out_data.pattern_active !== want.pattern_active) begin
            $display("%0t ns: pattern_active expected %0b actual %0b",
                     $time, want.pattern_active, out_data.pattern_active);
            errs++;
          end
          if (out_data.song_active !== want.song_active) begin
            $display("%0t ns: song_active expected %0b actual %0b",
                     $time, want.song_active, out_data.song_active);
            errs++;
          end
        end
        checked <= checked + 1;
      end
    end
    fail_count <= fail_count + errs;
    pending    <= pwm_expected.size();
  end

endmodule

[tb/tb_top.sv]
// Testbench top for buzzer_beep_and_song_sequencer_unit: clock, reset, request
// and volume stimulus, result back-pressure and the final verdict.
// Depends on bbss_pkg, bbss_chan_if, the sequencer RTL and bbss_pwm_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbss_pkg::*;

  typedef logic [VOL_W-1:0] vol_t;

  localparam logic [OP_W-1:0]  OP_SPARE_FIRST   = 3'd5;
  localparam logic [OP_W-1:0]  OP_SPARE_LAST    = 3'd7;
  localparam logic [NIB_W-1:0] LETTER_REST      = 4'd0;
  localparam logic [NIB_W-1:0] LETTER_C         = 4'd1;
  localparam logic [NIB_W-1:0] LETTER_B         = 4'd12;
  localparam logic [NIB_W-1:0] LETTER_SILENT_LO = 4'd14;
  localparam logic [NIB_W-1:0] LETTER_SILENT_HI = 4'd15;
  localparam int unsigned      SEGMENTS         = 6;
  localparam int unsigned      SEG_REQS         = 120;

  logic clk;
  logic rst_n;

  bbss_chan_if #(.T(in_req_t))  in_if  ();
  bbss_chan_if #(.T(out_rsp_t)) out_if ();
  bbss_chan_if #(.T(vol_t))     cfg_if ();

  int unsigned chk_fails;
  int unsigned chk_pending;
  int unsigned chk_checked;

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned n_sent;
  int unsigned n_songs;
  int unsigned n_beeps;
  int unsigned n_vol;

  buzzer_beep_and_song_sequencer_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  bbss_pwm_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_data    (in_if.data),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_data   (out_if.data),
    .cfg_valid  (cfg_if.valid),
    .cfg_ready  (cfg_if.ready),
    .cfg_data   (cfg_if.data),
    .fail_count (chk_fails),
    .pending    (chk_pending),
    .checked    (chk_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Safety net against a hung handshake
  initial begin
    #5ms;
    $display("buzzer_beep_and_song_sequencer_unit verification failed");
    $finish;
  end

  // Result back-pressure
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Fully random request fields with a chosen opcode
  function automatic in_req_t rand_req(input logic [OP_W-1:0] op);
    in_req_t r;
    r.opcode         = op;
    r.beep_count     = CNT_W'($urandom);
    r.beep_period    = TONE_W'($urandom);
    r.note_letter    = NIB_W'($urandom);
    r.note_octave    = NIB_W'($urandom);
    r.song_slot      = SLOT_W'($urandom);
    r.note_length_ms = TONE_W'($urandom);
    r.break_ms       = TONE_W'($urandom);
    return r;
  endfunction

  // Mostly pitched notes, sometimes a rest or a silent code; never the end marker
  function automatic logic [NIB_W-1:0] pick_letter();
    if ($urandom_range(9) < 8) return NIB_W'($urandom_range(LETTER_C, LETTER_B));
    case ($urandom_range(2))
      0:       return LETTER_REST;
      1:       return LETTER_SILENT_LO;
      default: return LETTER_SILENT_HI;
    endcase
  endfunction

  task automatic send_req(input in_req_t r);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= r;
    do @(posedge clk); while (!in_if.ready);
    n_sent++;
    if (r.opcode == OP_SONG_START) n_songs++;
    if (r.opcode == OP_BEEP_START) n_beeps++;
  endtask

  task automatic send_op(input logic [OP_W-1:0] op);
    send_req(rand_req(op));
  endtask

  task automatic write_note(input logic [SLOT_W-1:0] slot, input logic [NIB_W-1:0] letter,
                            input logic [NIB_W-1:0] octave);
    in_req_t r;
    r = rand_req(OP_NOTE_WR);
    r.song_slot   = slot;
    r.note_letter = letter;
    r.note_octave = octave;
    send_req(r);
  endtask

  task automatic start_beeps(input logic [NIB_W-1:0] letter, input logic [NIB_W-1:0] octave,
                             input logic [CNT_W-1:0] cnt, input logic [TONE_W-1:0] per);
    in_req_t r;
    r = rand_req(OP_BEEP_START);
    r.note_letter = letter;
    r.note_octave = octave;
    r.beep_count  = cnt;
    r.beep_period = per;
    send_req(r);
  endtask

  task automatic start_song(input logic [TONE_W-1:0] len, input logic [TONE_W-1:0] gap);
    in_req_t r;
    r = rand_req(OP_SONG_START);
    r.note_length_ms = len;
    r.break_ms       = gap;
    send_req(r);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_op(OP_TICK);
  endtask

  // Volume is only written with nothing in flight
  task automatic write_volume(input vol_t v);
    in_if.valid <= 1'b0;
    do @(posedge clk); while (chk_pending != 0);
    repeat (4) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    n_vol++;
  endtask

  // Short song from slot 0, then enough ticks to play it out
  task automatic play_song();
    int unsigned notes_n;
    int unsigned len;
    int unsigned gap;
    int unsigned n_ticks;
    in_req_t     r;
    notes_n = $urandom_range(1, 6);
    for (int unsigned s = 0; s < notes_n; s++) begin
      write_note(SLOT_W'(s), pick_letter(), NIB_W'($urandom));
    end
    // most songs carry an end marker, the rest run on into older notes
    if ($urandom_range(9) != 0) write_note(SLOT_W'(notes_n), END_LETTER, NIB_W'($urandom));
    len = ($urandom_range(9) != 0) ? $urandom_range(3) : $urandom_range(16'hFFFF);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: gap = 0;
      9:             gap = $urandom_range(16'hFFFF);
      default:       gap = $urandom_range(1, 3);
    endcase
    start_song(TONE_W'(len), TONE_W'(gap));
    if (len <= 3 && gap <= 3) n_ticks = (notes_n + 2) * (len + 1) * (gap + 2);
    else n_ticks = 20;
    // ticks with the occasional interruption
    repeat (n_ticks) begin
      case ($urandom_range(49))
        0: send_op(OP_SONG_STOP);
        1: start_beeps(pick_letter(), NIB_W'($urandom), CNT_W'($urandom_range(1, 3)),
                       TONE_W'($urandom_range(1, 3)));
        2: begin
          r = rand_req(OP_NOTE_WR);
          r.note_letter = pick_letter();
          send_req(r);
        end
        default: send_op(OP_TICK);
      endcase
    end
    if ($urandom_range(3) == 0) send_op(OP_SONG_STOP);
  endtask

  task automatic play_beeps();
    in_req_t     r;
    int unsigned n_ticks;
    r = rand_req(OP_BEEP_START);
    n_ticks = 12;
    case ($urandom_range(9))
      0: r.beep_count  = '0;
      1: r.beep_period = '0;
      2: ;
      default: begin
        r.beep_count  = CNT_W'($urandom_range(1, 4));
        r.beep_period = TONE_W'($urandom_range(1, 4));
        n_ticks = 2 * r.beep_count * r.beep_period + 2;
      end
    endcase
    send_req(r);
    send_ticks(n_ticks);
  endtask

  task automatic play_noise();
    repeat ($urandom_range(1, 6)) send_op(OP_W'($urandom_range(OP_TICK, OP_SPARE_LAST)));
  endtask

  initial begin
    vol_t        vol_plan [SEGMENTS];
    int unsigned seg_end;
    int unsigned pick;

    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    snd_idle_pct = 6;
    rcv_idle_pct = 49;
    n_sent       = 0;
    n_songs      = 0;
    n_beeps      = 0;
    n_vol        = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the whole note store without end markers so every read is defined
    for (int unsigned s = 0; s < SLOT_SPAN; s++) begin
      write_note(SLOT_W'(s), pick_letter(), NIB_W'($urandom));
    end
    // One note per tick across all slots: position wraps back to slot 0
    start_song('0, '0);
    send_ticks(SLOT_SPAN + 2);
    send_op(OP_SONG_STOP);

    // Directed: tick while idle, ignored pattern starts, rest and silent tones
    send_op(OP_TICK);
    start_beeps(LETTER_C, '0, '0, TONE_W'(5));
    start_beeps(LETTER_B, '1, '1, '0);
    start_beeps(LETTER_REST, '0, CNT_W'(1), TONE_W'(1));
    send_op(OP_TICK);
    start_beeps(LETTER_SILENT_LO, '0, '1, '1);
    start_beeps(LETTER_C, '0, CNT_W'(2), TONE_W'(1));
    send_ticks(3);
    // End marker on the very first note, longest note and break
    write_note('0, END_LETTER, '1);
    start_song('1, '1);
    send_op(OP_TICK);
    // Short song with breaks, a rest and a silent code, then stop mid-play
    write_note('0, NIB_W'(5), NIB_W'(2));
    write_note(SLOT_W'(1), LETTER_REST, '0);
    write_note(SLOT_W'(2), LETTER_SILENT_HI, '1);
    write_note(SLOT_W'(3), END_LETTER, '0);
    start_song('0, TONE_W'(1));
    send_ticks(6);
    send_op(OP_SONG_STOP);
    send_op(OP_SPARE_FIRST);
    send_op(OP_SPARE_LAST);

    // Random scenes over several volume settings and idle mixes
    vol_plan[0] = VOL_MAX;
    vol_plan[1] = '0;
    vol_plan[2] = '1;
    vol_plan[3] = vol_t'($urandom_range(1, 99));
    vol_plan[4] = VOL_MAX + 1'b1;
    vol_plan[5] = vol_t'($urandom_range(0, 127));
    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 2) begin
        snd_idle_pct = 49;
        rcv_idle_pct = 6;
      end else if (seg == 4) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      write_volume(vol_plan[seg]);
      seg_end = n_sent + SEG_REQS;
      while (n_sent < seg_end) begin
        pick = $urandom_range(99);
        if (pick < 55) play_song();
        else if (pick < 80) play_beeps();
        else play_noise();
      end
    end

    // Drain, then let the pipeline settle
    in_if.valid <= 1'b0;
    do @(posedge clk); while (chk_pending != 0);
    repeat (10) @(posedge clk);
    $display("Summary: %0d requests with %0d song starts and %0d beep pattern starts",
             n_sent, n_songs, n_beeps);
    $display("Summary: %0d results compared across %0d volume settings",
             chk_checked, n_vol);
    if (chk_fails == 0) begin
      $display("buzzer_beep_and_song_sequencer_unit verification clean");
    end else begin
      $display("buzzer_beep_and_song_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bbss_pkg.sv
rtl/bbss_chan_if.sv
rtl/bbss_note_mem.sv
rtl/bbss_exec.sv
rtl/bbss_duty.sv
rtl/buzzer_beep_and_song_sequencer_unit.sv
tb/bbss_pwm_checker.sv
tb/tb_top.sv
